FILE: design/particulate_sensor_frame_parser_macros.svh
// Assertion macros shared by the frame parser modules.
`ifndef PARTICULATE_SENSOR_FRAME_PARSER_MACROS_SVH
`define PARTICULATE_SENSOR_FRAME_PARSER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PSFP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("frame parser assertion failed");

// Check that a condition never holds outside reset.
`define PSFP_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("frame parser forbidden condition seen");

`endif

FILE: design/psfp_pkg.sv
// Types and constants of the particulate sensor frame parser.
package psfp_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int IDX_W      = 4;
   localparam int POS_W      = 5;
   localparam int SUM_W      = 13;
   localparam int BANK_WORDS = 16;
   localparam int RAM_DEPTH  = 2 * BANK_WORDS;
   localparam int RAM_AW     = $clog2(RAM_DEPTH);

   localparam logic [BYTE_W-1:0] HDR0 = 8'h42;
   localparam logic [BYTE_W-1:0] HDR1 = 8'h4D;

   typedef struct packed {
      logic bank;
      logic ok;
   } frame_cmd_type;

   typedef struct packed {
      logic                en;
      logic [RAM_AW-1:0]   addr;
      logic [WORD_W-1:0]   data;
   } ram_wr_type;

   typedef struct packed {
      logic       en;
      logic [RAM_AW-1:0] addr;
   } ram_rd_type;

endpackage

FILE: design/psfp_if.sv
// Valid/ready channel interfaces for received bytes and parsed words.
interface psfp_req_if;
   logic                          valid;
   logic                          ready;
   logic [psfp_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface psfp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psfp_pkg::IDX_W-1:0]    word_index;
   logic [psfp_pkg::WORD_W-1:0]   word_value;
   logic                          checksum_ok;
   logic                          last;

   modport source (output valid, output word_index, output word_value,
                   output checksum_ok, output last, input ready);
   modport sink (input valid, input word_index, input word_value,
                 input checksum_ok, input last, output ready);
endinterface

FILE: design/psfp_ram.sv
// Generic simple dual-port RAM with registered read.
module psfp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/psfp_cmd_fifo.sv
// Two-entry queue of finished-frame commands between front and back.
`include "particulate_sensor_frame_parser_macros.svh"

module psfp_cmd_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  psfp_pkg::frame_cmd_type  push_cmd,
   input  logic                     pop,
   output psfp_pkg::frame_cmd_type  head,
   output logic                     head_valid,
   output logic                     full
);

   psfp_pkg::frame_cmd_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);

   `PSFP_ASSERT_NEVER(a_no_overflow, push && !pop && count_ff == 2'd2)
   `PSFP_ASSERT_NEVER(a_no_underflow, pop && count_ff == 2'd0)

endmodule

FILE: design/psfp_front.sv
// Byte-side front end: frame position, header check, byte sum, word assembly.
`include "particulate_sensor_frame_parser_macros.svh"

module psfp_front #(
   parameter int FRAME_WORDS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [psfp_pkg::BYTE_W-1:0]   rx_byte,
   output psfp_pkg::ram_wr_type          wr,
   output logic                          push,
   output psfp_pkg::frame_cmd_type       cmd
);

   localparam int FRAME_BYTES = 2 * FRAME_WORDS + 2;
   localparam int SUM_BYTES   = 2 * FRAME_WORDS;
   localparam logic [psfp_pkg::POS_W-1:0] LAST_POS = psfp_pkg::POS_W'(FRAME_BYTES - 1);
   localparam logic [psfp_pkg::POS_W-1:0] SUM_END  = psfp_pkg::POS_W'(SUM_BYTES);

   logic [psfp_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [psfp_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                        hdr_ff, hdr_in;
   logic [psfp_pkg::BYTE_W-1:0] hold_ff, hold_in;
   logic                        bank_ff, bank_in;
   logic                        is_last;
   logic [psfp_pkg::WORD_W-1:0] word;
   logic [psfp_pkg::IDX_W-1:0]  word_idx;

   always_comb begin
      is_last  = (pos_ff == LAST_POS);
      word     = {hold_ff, rx_byte};
      word_idx = pos_ff[psfp_pkg::POS_W-1:1] - psfp_pkg::IDX_W'(1);

      priority if (pos_ff == '0) begin
         hdr_in = (rx_byte == psfp_pkg::HDR0);
      end else if (pos_ff == psfp_pkg::POS_W'(1)) begin
         hdr_in = hdr_ff && (rx_byte == psfp_pkg::HDR1);
      end else begin
         hdr_in = hdr_ff;
      end

      priority if (pos_ff == '0) begin
         sum_in = psfp_pkg::SUM_W'(rx_byte);
      end else if (pos_ff < SUM_END) begin
         sum_in = sum_ff + psfp_pkg::SUM_W'(rx_byte);
      end else begin
         sum_in = sum_ff;
      end

      hold_in = (pos_ff >= psfp_pkg::POS_W'(2) && !pos_ff[0]) ? rx_byte : hold_ff;
      pos_in  = is_last ? '0 : pos_ff + psfp_pkg::POS_W'(1);

      wr.en   = accept && (pos_ff >= psfp_pkg::POS_W'(2)) && pos_ff[0];
      wr.addr = {bank_ff, word_idx};
      wr.data = word;

      push     = accept && is_last && hdr_ff;
      cmd.bank = bank_ff;
      cmd.ok   = ({{(psfp_pkg::WORD_W - psfp_pkg::SUM_W){1'b0}}, sum_ff} == word);
      bank_in  = push ? ~bank_ff : bank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sum_ff  <= '0;
         hdr_ff  <= 1'b0;
         bank_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         hdr_ff  <= hdr_in;
         bank_ff <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

   `PSFP_ASSERT(a_bank_flips_on_push, push |=> bank_ff != $past(bank_ff))
   `PSFP_ASSERT(a_push_at_frame_end, push |=> pos_ff == '0)

endmodule

FILE: design/psfp_back.sv
// Word-side back end: reads a finished frame from RAM and emits its words.
`include "particulate_sensor_frame_parser_macros.svh"

module psfp_back #(
   parameter int FRAME_WORDS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psfp_pkg::frame_cmd_type       head,
   input  logic                          head_valid,
   output logic                          pop,
   output psfp_pkg::ram_rd_type          rd,
   input  logic [psfp_pkg::WORD_W-1:0]   rd_data,
   psfp_rsp_if.source                    rsp_ch
);

   localparam logic [psfp_pkg::IDX_W-1:0] LAST_IDX = psfp_pkg::IDX_W'(FRAME_WORDS - 1);

   logic [psfp_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                        issued_all_ff, issued_all_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [psfp_pkg::IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                        out_vld_ff, out_vld_in;
   logic [psfp_pkg::IDX_W-1:0]  out_idx_ff;
   logic [psfp_pkg::WORD_W-1:0] out_value_ff;
   logic                        out_ok_ff;
   logic                        out_last_ff;
   logic                        issue;
   logic                        load;
   logic                        rd_last;

   always_comb begin
      load    = rd_vld_ff && (!out_vld_ff || rsp_ch.ready);
      issue   = head_valid && !issued_all_ff && (!rd_vld_ff || load);
      rd_last = (rd_idx_ff == LAST_IDX);
      pop     = load && rd_last;

      rd.en   = issue;
      rd.addr = {head.bank, idx_ff};

      if (issue) begin
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + psfp_pkg::IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end

      priority if (pop) begin
         issued_all_in = 1'b0;
      end else if (issue && idx_ff == LAST_IDX) begin
         issued_all_in = 1'b1;
      end else begin
         issued_all_in = issued_all_ff;
      end

      priority if (issue) begin
         rd_vld_in = 1'b1;
      end else if (load) begin
         rd_vld_in = 1'b0;
      end else begin
         rd_vld_in = rd_vld_ff;
      end

      rd_idx_in  = issue ? idx_ff : rd_idx_ff;
      out_vld_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         issued_all_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         issued_all_ff <= issued_all_in;
         rd_vld_ff     <= rd_vld_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (load) begin
         out_idx_ff   <= rd_idx_ff;
         out_value_ff <= rd_data;
         out_ok_ff    <= head.ok;
         out_last_ff  <= rd_last;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.word_index  = out_idx_ff;
   assign rsp_ch.word_value  = out_value_ff;
   assign rsp_ch.checksum_ok = out_ok_ff;
   assign rsp_ch.last        = out_last_ff;

   `PSFP_ASSERT(a_issue_has_frame, issue |-> head_valid)
   `PSFP_ASSERT(a_pop_after_all_issued, pop |-> issued_all_ff)

endmodule

FILE: design/particulate_sensor_frame_parser.sv
// Particulate sensor frame parser: serial bytes in, 16-bit frame words out.
//
// Bytes are counted into fixed frames of 2*FRAME_WORDS+2 bytes with no resync on
// the header. A frame whose first two bytes are 0x42 0x4D yields FRAME_WORDS
// big-endian words after its last byte, each flagged with whether the sum of the
// leading 2*FRAME_WORDS bytes equals the final (checksum) word; the final word
// carries last. Bytes are taken one per cycle while req_ch.ready is high. The
// front end stores words into a two-bank RAM; a two-entry queue hands finished
// frames to the back end, which reads one word per cycle, when the sink does not
// stall, through the RAM's registered read port. req_ch.ready drops only while
// two finished frames still wait to be emitted.
module particulate_sensor_frame_parser #(
   parameter int FRAME_WORDS = 15
) (
   input  logic         clock,
   input  logic         reset,
   psfp_req_if.sink     req_ch,
   psfp_rsp_if.source   rsp_ch
);

   logic                           accept;
   logic                           push;
   logic                           pop;
   logic                           head_valid;
   logic                           q_full;
   psfp_pkg::frame_cmd_type        push_cmd;
   psfp_pkg::frame_cmd_type        head;
   psfp_pkg::ram_wr_type           wr;
   psfp_pkg::ram_rd_type           rd;
   logic [psfp_pkg::WORD_W-1:0]    rd_data;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   psfp_front #(
      .FRAME_WORDS (FRAME_WORDS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_ch.rx_byte),
      .wr      (wr),
      .push    (push),
      .cmd     (push_cmd)
   );

   psfp_ram #(
      .WIDTH (psfp_pkg::WORD_W),
      .DEPTH (psfp_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd.en),
      .rd_addr (rd.addr),
      .rd_data (rd_data)
   );

   psfp_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   psfp_back #(
      .FRAME_WORDS (FRAME_WORDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rd         (rd),
      .rd_data    (rd_data),
      .rsp_ch     (rsp_ch)
   );

endmodule
